@@ sv/abq_pkg.sv @@
// Shared types, widths and constants of the absmax block quantizer.
package abq_pkg;

    localparam int BLOCK_SIZE = 32;
    localparam int CNT_W      = $clog2(BLOCK_SIZE + 1);
    localparam int ADDR_W     = $clog2(BLOCK_SIZE);

    localparam int SAMPLE_W   = 16;
    localparam int SCALE_W    = 21;
    localparam int CODE_W     = 8;

    // serial divider sizing
    localparam int NUM_W      = 25;  // 512*amax + 127 and |2*D*x + amax|
    localparam int DEN_W      = 17;  // 2*amax
    localparam int REM_W      = DEN_W;
    localparam int QUO_W      = SCALE_W;
    localparam int CODE_QUO_W = 8;   // code quotients never exceed 127
    localparam int STEP_W     = $clog2(QUO_W + 1);

    localparam logic [7:0] DIV_4BIT = 8'd7;
    localparam logic [7:0] DIV_8BIT = 8'd127;

    localparam logic MODE_4BIT = 1'b0;
    localparam logic MODE_8BIT = 1'b1;

    localparam logic [3:0] NIB_OFFSET = 4'd8;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       row_end;
    } t_req;

    typedef struct packed {
        logic               is_scale;
        logic [SCALE_W-1:0] scale;
        logic [CODE_W-1:0]  code_byte;
        logic               block_last;
        logic               row_last;
    } t_result;

    // block hand-off from the buffer to the sequencer
    typedef struct packed {
        logic                go;
        logic [CNT_W-1:0]    count;
        logic [SAMPLE_W-1:0] amax;
        logic                row_end;
        logic                mode;
    } t_blk;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_rd_req;

    typedef struct packed {
        logic             start;
        logic             wide;   // 1: full scale quotient, 0: code quotient
        logic [NUM_W-1:0] numer;
        logic [DEN_W-1:0] denom;
    } t_div_cmd;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quot;
    } t_div_rsp;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_SCALE_GO,
        SEQ_SCALE_WAIT,
        SEQ_READ,
        SEQ_MUL,
        SEQ_DIV_GO,
        SEQ_DIV_WAIT,
        SEQ_CODE
    } t_seq_state;

endpackage

@@ sv/abq_serial_div.sv @@
// Restoring serial divider, one quotient bit per cycle.
module abq_serial_div import abq_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_cmd i_cmd,
    output t_div_rsp o_rsp
);

    logic              r_run;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [REM_W-1:0]  r_rem;
    logic [NUM_W-1:0]  r_num;
    logic [DEN_W-1:0]  r_den;
    logic [QUO_W-1:0]  r_quo;

    logic [REM_W:0]    rem_sh;
    logic [REM_W:0]    diff;
    logic              ge;
    logic [REM_W-1:0]  n_rem;

    assign rem_sh = {r_rem, r_num[NUM_W-1]};
    assign diff   = rem_sh - {1'b0, r_den};
    assign ge     = rem_sh >= {1'b0, r_den};
    assign n_rem  = ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_run <= 1'b1;
            end else if (r_run && r_cnt == STEP_W'(1)) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_den <= i_cmd.denom;
            r_quo <= '0;
            if (i_cmd.wide) begin
                r_cnt <= STEP_W'(QUO_W);
                r_rem <= REM_W'(i_cmd.numer >> QUO_W);
                r_num <= i_cmd.numer << (NUM_W - QUO_W);
            end else begin
                r_cnt <= STEP_W'(CODE_QUO_W);
                r_rem <= REM_W'(i_cmd.numer >> CODE_QUO_W);
                r_num <= i_cmd.numer << (NUM_W - CODE_QUO_W);
            end
        end else if (r_run) begin
            r_cnt <= r_cnt - STEP_W'(1);
            r_rem <= n_rem;
            r_num <= r_num << 1;
            r_quo <= {r_quo[QUO_W-2:0], ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

endmodule

@@ sv/abq_seq.sv @@
// Sequencer: scale and code generation over the shared divider.
module abq_seq import abq_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_blk                       i_blk,
    input  logic signed [SAMPLE_W-1:0] i_rd_data,
    input  t_div_rsp                   i_div,
    output t_rd_req                    o_rd,
    output t_div_cmd                   o_div,
    output logic                       o_busy,
    output t_result                    o_res,
    output logic                       o_res_vld
);

    t_seq_state r_state, n_state;

    logic [CNT_W-1:0]    r_count;
    logic [SAMPLE_W-1:0] r_amax;
    logic                r_rend;
    logic                r_mode;
    logic [CNT_W-1:0]    r_idx;
    logic                r_half;
    logic [3:0]          r_lo_nib;
    logic signed [NUM_W-1:0] r_tnum;
    t_result             r_res;
    logic                r_res_vld;

    t_result             n_res;
    logic                n_res_vld;

    logic [CNT_W-1:0]        idx_inc;
    logic                    code_last;
    logic [7:0]              div_c;
    logic signed [8:0]       twod;
    logic signed [NUM_W-1:0] prod;
    logic signed [NUM_W-1:0] tnum;
    logic [NUM_W-1:0]        tmag;
    logic [NUM_W-1:0]        scale_num;
    logic [DEN_W-1:0]        scale_den;
    logic signed [CODE_QUO_W:0] q_mag;
    logic signed [CODE_QUO_W:0] q_sgn;
    logic signed [CODE_QUO_W:0] q_lo;
    logic signed [CODE_QUO_W:0] q_hi;
    logic signed [CODE_QUO_W:0] q_clp;
    logic [3:0]              nib;

    assign idx_inc   = r_idx + CNT_W'(1);
    assign code_last = (idx_inc == r_count);

    // scale = (512*amax + D) / (2*D)
    assign div_c     = (r_mode == MODE_8BIT) ? DIV_8BIT : DIV_4BIT;
    assign scale_num = NUM_W'({r_amax, 9'b0}) + NUM_W'(div_c);
    assign scale_den = DEN_W'({div_c, 1'b0});

    // code numerator 2*D*x + amax, then sign and magnitude for the divider
    assign twod = signed'({div_c, 1'b0});
    assign prod = twod * i_rd_data;
    assign tnum = prod + signed'(NUM_W'(r_amax));
    assign tmag = r_tnum[NUM_W-1] ? NUM_W'(-r_tnum) : NUM_W'(r_tnum);

    assign q_mag = signed'({1'b0, i_div.quot[CODE_QUO_W-1:0]});
    assign q_lo  = (r_mode == MODE_8BIT) ? -9'sd127 : -9'sd8;
    assign q_hi  = (r_mode == MODE_8BIT) ?  9'sd127 :  9'sd7;

    always_comb begin
        if (r_amax == '0) begin
            q_sgn = '0;
        end else if (r_tnum[NUM_W-1]) begin
            q_sgn = -q_mag;
        end else begin
            q_sgn = q_mag;
        end
        if (q_sgn < q_lo) begin
            q_clp = q_lo;
        end else if (q_sgn > q_hi) begin
            q_clp = q_hi;
        end else begin
            q_clp = q_sgn;
        end
    end

    assign nib = q_clp[3:0] + NIB_OFFSET;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            SEQ_IDLE:       if (i_blk.go) n_state = SEQ_SCALE_GO;
            SEQ_SCALE_GO:   n_state = SEQ_SCALE_WAIT;
            SEQ_SCALE_WAIT: if (i_div.done) n_state = SEQ_READ;
            SEQ_READ:       n_state = SEQ_MUL;
            SEQ_MUL:        n_state = SEQ_DIV_GO;
            SEQ_DIV_GO:     n_state = SEQ_DIV_WAIT;
            SEQ_DIV_WAIT:   if (i_div.done) n_state = SEQ_CODE;
            SEQ_CODE:       n_state = code_last ? SEQ_IDLE : SEQ_READ;
            default:        n_state = SEQ_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_div     = '0;
        o_rd      = '0;
        n_res     = '0;
        n_res_vld = 1'b0;
        unique case (r_state)
            SEQ_SCALE_GO: begin
                o_div.start = 1'b1;
                o_div.wide  = 1'b1;
                o_div.numer = scale_num;
                o_div.denom = scale_den;
            end
            SEQ_SCALE_WAIT: begin
                if (i_div.done) begin
                    n_res_vld      = 1'b1;
                    n_res.is_scale = 1'b1;
                    n_res.scale    = i_div.quot;
                end
            end
            SEQ_READ: begin
                o_rd.en   = 1'b1;
                o_rd.addr = r_idx[ADDR_W-1:0];
            end
            SEQ_DIV_GO: begin
                o_div.start = 1'b1;
                o_div.numer = tmag;
                o_div.denom = DEN_W'({r_amax, 1'b0});
            end
            SEQ_CODE: begin
                n_res_vld = (r_mode == MODE_8BIT) || r_half || code_last;
                if (r_mode == MODE_8BIT) begin
                    n_res.code_byte = q_clp[CODE_W-1:0];
                end else if (r_half) begin
                    n_res.code_byte = {nib, r_lo_nib};
                end else begin
                    n_res.code_byte = {NIB_OFFSET, nib};
                end
                n_res.block_last = code_last;
                n_res.row_last   = code_last && r_rend;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= SEQ_IDLE;
            r_res_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_res_vld <= n_res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (r_state == SEQ_IDLE && i_blk.go) begin
            r_count <= i_blk.count;
            r_amax  <= i_blk.amax;
            r_rend  <= i_blk.row_end;
            r_mode  <= i_blk.mode;
            r_idx   <= '0;
            r_half  <= 1'b0;
        end
        if (r_state == SEQ_MUL) begin
            r_tnum <= tnum;
        end
        if (r_state == SEQ_CODE) begin
            r_idx <= idx_inc;
            if (r_mode == MODE_4BIT) begin
                if (n_res_vld) begin
                    r_half <= 1'b0;
                end else begin
                    r_half   <= 1'b1;
                    r_lo_nib <= nib;
                end
            end
        end
    end

    assign o_busy    = (r_state != SEQ_IDLE);
    assign o_res     = r_res;
    assign o_res_vld = r_res_vld;

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_div.done |-> (r_state == SEQ_SCALE_WAIT || r_state == SEQ_DIV_WAIT))
        else $error("divider finished outside a wait state");

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_vld && r_res.block_last) |=> !r_res_vld)
        else $error("result strobe after the last item of a block");

    a_scale_then_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_vld && r_res.is_scale) |-> (r_state == SEQ_READ))
        else $error("scale item not followed by the first sample read");

endmodule

@@ sv/absmax_block_quantizer_core.sv @@
// Top level of the absmax block quantizer: sample buffer, block max, config.
// A block of n samples ends on its last request; the scale item comes
// first, then each sample is read, multiplied, put through an 8-step serial
// divide and coded; in 4-bit mode one byte is emitted per pair of samples.
// Throughput: one request per cycle while a block fills; busy stays high from
// block end until the last result is out. The receiver cannot stall.
// Reset (synchronous, i_rst_n low): empty block, amax 0, 4-bit mode, idle.
module absmax_block_quantizer_core import abq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_req    i_req,
    input  logic    i_cfg_we,
    input  logic    i_cfg_data,
    output t_result o_res,
    output logic    o_res_vld
);

    // code_mode register; sampled into the sequencer at block end
    logic r_code_mode;

    // sample buffer, one write port (incoming requests), one read port (sequencer)
    logic signed [SAMPLE_W-1:0] r_mem [BLOCK_SIZE];
    logic signed [SAMPLE_W-1:0] r_rd_data;

    logic [CNT_W-1:0]    r_fill;
    logic [SAMPLE_W-1:0] r_amax;

    logic                accept;
    logic                blk_end;
    logic [SAMPLE_W-1:0] sample_u;
    logic [SAMPLE_W-1:0] mag;
    logic [SAMPLE_W-1:0] new_amax;

    t_blk     blk;
    t_rd_req  rd;
    t_div_cmd div_cmd;
    t_div_rsp div_rsp;
    logic     seq_busy;

    assign accept  = start && !busy;
    // block closes when full or on the row's last sample
    assign blk_end = accept && (r_fill == CNT_W'(BLOCK_SIZE - 1) || i_req.row_end);

    // magnitude of -32768 is 32768, which still fits 16 bits unsigned
    assign sample_u = i_req.sample;
    assign mag      = sample_u[SAMPLE_W-1] ? (~sample_u + SAMPLE_W'(1)) : sample_u;
    assign new_amax = (mag > r_amax) ? mag : r_amax;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_mode <= MODE_4BIT;
            r_fill      <= '0;
            r_amax      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_code_mode <= i_cfg_data;
            end
            if (blk_end) begin
                r_fill <= '0;
                r_amax <= '0;
            end else if (accept) begin
                r_fill <= r_fill + CNT_W'(1);
                r_amax <= new_amax;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mem[r_fill[ADDR_W-1:0]] <= i_req.sample;
        end
        if (rd.en) begin
            r_rd_data <= r_mem[rd.addr];
        end
    end

    // block hand-off: count and amax include the closing sample
    assign blk.go      = blk_end;
    assign blk.count   = r_fill + CNT_W'(1);
    assign blk.amax    = new_amax;
    assign blk.row_end = i_req.row_end;
    assign blk.mode    = r_code_mode;

    abq_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_blk     (blk),
        .i_rd_data (r_rd_data),
        .i_div     (div_rsp),
        .o_rd      (rd),
        .o_div     (div_cmd),
        .o_busy    (seq_busy),
        .o_res     (o_res),
        .o_res_vld (o_res_vld)
    );

    abq_serial_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (div_cmd),
        .o_rsp   (div_rsp)
    );

    assign busy = seq_busy;

    a_busy_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        blk_end |=> busy)
        else $error("block closed but quantizer not busy");

    a_empty_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (r_fill == '0 && r_amax == '0))
        else $error("buffer not cleared while a block is being coded");

    a_fill_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < CNT_W'(BLOCK_SIZE))
        else $error("fill count past the block size");

endmodule

@@ test/abq_quant_checker.sv @@
`timescale 1ns / 1ps
// Checker for the absmax block quantizer: predicts scale and code items and compares them.
module abq_quant_checker import abq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_busy,
    input  t_req    i_req,
    input  logic    i_cfg_we,
    input  logic    i_cfg_data,
    input  t_result i_res,
    input  logic    i_res_vld,
    output int      o_err_cnt,
    output int      o_pending
);

    localparam longint C8_LIM = 127;
    localparam longint C4_MIN = -8;
    localparam longint C4_MAX = 7;

    logic signed [SAMPLE_W-1:0] held [BLOCK_SIZE];
    logic [SAMPLE_W-1:0]        peak;      // largest magnitude in the open block
    int unsigned                fill;
    logic                       mode;
    t_result                    quant_items_q [$];
    int                         errs;

    initial begin
        errs = 0;
    end

    // code = trunc((2*D*x + amax) / (2*amax)), clamped; 0 for an all-zero block
    function automatic longint quant_code(longint x, longint amax, longint d,
                                          longint lo, longint hi);
        longint q;
        if (amax == 0)
            return 0;
        q = (2 * d * x + amax) / (2 * amax);
        if (q < lo)
            q = lo;
        if (q > hi)
            q = hi;
        return q;
    endfunction

    function automatic void match_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errs++;
        end
    endfunction

    // block end: one scale item, then the codes of every held sample
    task automatic close_block(input logic row_end);
        t_result     item;
        longint      amax;
        longint      d;
        longint      lo_c;
        longint      hi_c;
        int unsigned i;
        amax = longint'(peak);
        d    = (mode == MODE_8BIT) ? longint'(DIV_8BIT) : longint'(DIV_4BIT);

        item          = '0;
        item.is_scale = 1'b1;
        item.scale    = SCALE_W'((512 * amax + d) / (2 * d));
        quant_items_q.push_back(item);

        if (mode == MODE_8BIT) begin
            for (i = 0; i < fill; i++) begin
                item            = '0;
                item.code_byte  = CODE_W'(quant_code(held[i], amax, d, -C8_LIM, C8_LIM));
                item.block_last = (i + 1 == fill);
                item.row_last   = item.block_last && row_end;
                quant_items_q.push_back(item);
            end
        end else begin
            for (i = 0; i < fill; i += 2) begin
                lo_c = quant_code(held[i], amax, d, C4_MIN, C4_MAX) + longint'(NIB_OFFSET);
                // odd tail: the high nibble carries code 0
                hi_c = longint'(NIB_OFFSET);
                if (i + 1 < fill)
                    hi_c = quant_code(held[i + 1], amax, d, C4_MIN, C4_MAX)
                         + longint'(NIB_OFFSET);
                item            = '0;
                item.code_byte  = {hi_c[3:0], lo_c[3:0]};
                item.block_last = (i + 2 >= fill);
                item.row_last   = item.block_last && row_end;
                quant_items_q.push_back(item);
            end
        end
        fill = 0;
        peak = '0;
    endtask

    always @(posedge i_clk) begin
        t_result want;
        longint  x;
        longint  mag;
        if (!i_rst_n) begin
            quant_items_q.delete();
            peak = '0;
            fill = 0;
            mode = MODE_4BIT;
        end else begin
            if (i_res_vld) begin
                if (quant_items_q.size() == 0) begin
                    $error("result item with none expected: %p", i_res);
                    errs++;
                end else begin
                    want = quant_items_q.pop_front();
                    match_field("is_scale",   want.is_scale,   i_res.is_scale);
                    match_field("scale",      want.scale,      i_res.scale);
                    match_field("code_byte",  want.code_byte,  i_res.code_byte);
                    match_field("block_last", want.block_last, i_res.block_last);
                    match_field("row_last",   want.row_last,   i_res.row_last);
                end
            end

            if (i_cfg_we)
                mode = i_cfg_data;

            if (i_start && !i_busy) begin
                x   = longint'($signed(i_req.sample));
                mag = (x < 0) ? -x : x;
                if (fill >= BLOCK_SIZE)
                    fill = 0;
                held[fill] = i_req.sample;
                fill++;
                if (mag > longint'(peak))
                    peak = mag[SAMPLE_W-1:0];
                if (fill == BLOCK_SIZE || i_req.row_end)
                    close_block(i_req.row_end);
            end
        end
        o_err_cnt <= errs;
        o_pending <= quant_items_q.size();
    end

endmodule

@@ test/tb_absmax_block_quantizer_core.sv @@
`timescale 1ns / 1ps
// Testbench top for the absmax block quantizer: clock, reset, request stimulus and verdict.
module tb_absmax_block_quantizer_core;
    import abq_pkg::*;

    // Cycles to let pass after the last expected item before a mode write or
    // the verdict, with margin.
    localparam int SETTLE_CYCLES = 48;
    localparam int RAND_PHASES   = 6;
    localparam int PHASE_ITEMS   = 40;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    t_req    i_req;
    logic    i_cfg_we;
    logic    i_cfg_data;
    t_result o_res;
    logic    o_res_vld;

    int err_cnt;
    int pending;
    int idle_pct;   // chance in percent of an idle burst before a request
    int sent;

    absmax_block_quantizer_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_res      (o_res),
        .o_res_vld  (o_res_vld)
    );

    // The checker sees the same pins as the block; it owns all prediction.
    abq_quant_checker u_quant_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_busy     (busy),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_res      (o_res),
        .i_res_vld  (o_res_vld),
        .o_err_cnt  (err_cnt),
        .o_pending  (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop. Worst case is far below this: ~650 requests, each at most an
    // idle gap plus a one-sample block, plus phase drains.
    initial begin
        #4_000_000;
        $display("status: fail");
        $finish;
    end

    // One request. busy is sampled at the falling edge, where it is stable
    // for the coming rising edge, so the accept decision is race free.
    // start is left high on return; the next call either keeps it high or
    // drops it for an idle burst, never both in one step.
    task automatic issue_request(input logic signed [SAMPLE_W-1:0] s, input logic re);
        t_req r;
        logic stalled;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        r.sample  = s;
        r.row_end = re;
        start <= 1'b1;
        i_req <= r;
        do begin
            @(negedge i_clk);
            stalled = busy;
            @(posedge i_clk);
        end while (stalled);
        sent++;
    endtask

    // Stop sending and wait until every expected item has come out, then let
    // the block finish any trailing work before anything else happens.
    task automatic quiesce();
        start <= 1'b0;
        do
            @(negedge i_clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Called right after a rising edge with start low.
    task automatic write_mode(input logic m);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Row content: mostly values within a per-row magnitude span, so codes
    // spread over the whole range, with extremes sprinkled in.
    function automatic logic signed [SAMPLE_W-1:0] pick_sample(int span);
        int v;
        case ($urandom_range(15))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return '0;
            default: begin
                if (span >= SAMPLE_W)
                    return SAMPLE_W'($urandom);
                v = $urandom_range((1 << span) - 1);
                if ($urandom_range(1))
                    v = -v;
                return SAMPLE_W'(v);
            end
        endcase
    endfunction

    // A row ends with row_end. Lengths favor full blocks, two blocks, one short
    // of / one past a block, and tiny rows. Now and then a noisy row carries
    // stray row_end marks that cut blocks short.
    task automatic run_row();
        int   len;
        int   span;
        int   k;
        logic noisy;
        case ($urandom_range(7))
            0: len = BLOCK_SIZE;
            1: len = 2 * BLOCK_SIZE;
            2: len = $urandom_range(1, 4);
            3: len = BLOCK_SIZE - 1 + 2 * $urandom_range(1);
            default: len = $urandom_range(1, BLOCK_SIZE + 8);
        endcase
        span  = $urandom_range(SAMPLE_W);
        noisy = ($urandom_range(15) == 0);
        for (k = 0; k < len; k++)
            issue_request(pick_sample(span),
                          (k == len - 1) || (noisy && $urandom_range(3) == 0));
    endtask

    initial begin
        int   ph;
        int   quota;
        logic m;
        start      <= 1'b0;
        i_req      <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_data <= 1'b0;
        i_rst_n    <= 1'b0;
        sent     = 0;
        idle_pct = 30;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed: 4-bit mode out of reset ----
        issue_request(16'sd0, 1'b1);              // all-zero block, amax 0
        issue_request(16'sh7FFF, 1'b0);           // extremes, -32768 magnitude,
        issue_request(16'sh8000, 1'b0);           // odd count pads high nibble
        issue_request(16'sd5, 1'b1);
        issue_request(16'sd3, 1'b0);              // rounding halves around amax 7
        issue_request(-16'sd3, 1'b0);
        issue_request(16'sd7, 1'b1);
        quiesce();

        // ---- directed: 8-bit mode ----
        write_mode(MODE_8BIT);
        issue_request(16'sh8000, 1'b1);           // single sample, full-scale negative
        issue_request(16'sd1, 1'b0);
        issue_request(-16'sd1, 1'b0);
        issue_request(16'sd127, 1'b0);
        issue_request(-16'sd128, 1'b1);
        // mode switched with a block half filled: divisor is taken at block end
        issue_request(16'sd100, 1'b0);
        issue_request(-16'sd200, 1'b0);
        quiesce();
        write_mode(MODE_4BIT);
        issue_request(16'sd300, 1'b1);

        // ---- random phases; each starts from an idle, drained block ----
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            quiesce();
            if (ph == 0)
                m = MODE_8BIT;
            else if (ph == 1)
                m = MODE_4BIT;
            else
                m = logic'($urandom_range(1));
            write_mode(m);
            // last phase runs back to back; earlier ones mix gap densities
            if (ph == RAND_PHASES - 1)
                idle_pct = 0;
            else
                case ($urandom_range(2))
                    0: idle_pct = 0;
                    1: idle_pct = 25;
                    default: idle_pct = 60;
                endcase
            quota = sent + PHASE_ITEMS;
            while (sent < quota)
                run_row();
        end

        quiesce();
        @(negedge i_clk);
        if (err_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ files.f @@
sv/abq_pkg.sv
sv/abq_serial_div.sv
sv/abq_seq.sv
sv/absmax_block_quantizer_core.sv
test/abq_quant_checker.sv
test/tb_absmax_block_quantizer_core.sv
